>>> design/lts_pkg.sv
// Shared types, codes and a helper function for the lexical token scanner.
// Used by lts_ctrl, lts_dp and lexical_token_scanner_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

	localparam int MAX_LEN_DEF     = 20;
	localparam int SYM_ENTRIES_DEF = 256;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_OP,
		MODE_NUM,
		MODE_ID
	} mode_t;

	typedef enum logic [2:0] {
		KIND_OP      = 3'd0,
		KIND_SPECIAL = 3'd1,
		KIND_NUM     = 3'd2,
		KIND_KW      = 3'd3,
		KIND_NEWID   = 3'd4,
		KIND_FULL    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		SRC_BUF,
		SRC_PEND,
		SRC_CHAR,
		SRC_ZERO
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FIN,
		ST_FIN_OP,
		ST_EMIT_BUF,
		ST_SRCH_LEN,
		ST_SRCH_CHK,
		ST_SRCH_CMP,
		ST_STORE,
		ST_FULL,
		ST_FIN_END,
		ST_PAIR0,
		ST_PAIR1,
		ST_START
	} state_t;

	typedef struct packed {
		logic  accept;
		logic  emit;
		src_t  src;
		kind_t kind;
		logic  last;
		logic  bump;
		logic  append;
		logic  set_mode;
		mode_t mode;
		logic  load_pend;
		logic  fin_done;
		logic  line_inc;
		logic  i_clr;
		logic  i_inc;
		logic  j_clr;
		logic  j_inc;
		logic  cnt_inc;
		logic  wr_sym;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  eoi;
		logic  c_op;
		logic  c_special;
		logic  c_digit;
		logic  c_alpha;
		logic  c_nl;
		logic  c_ident;
		logic  pair_ok;
		logic  kw_hit;
		logic  j_end;
		logic  full;
		logic  len_eq;
		logic  chr_eq;
		logic  i_last;
		logic  out_free;
	} status_t;

	function automatic logic is_keyword(input logic [4:0][7:0] w, input logic [4:0] n);
		logic hit;
		hit = 1'b0;
		if (n == 5'd2 && w[0] == "i" && w[1] == "f")
			hit = 1'b1;
		if (n == 5'd3 && w[0] == "i" && w[1] == "n" && w[2] == "t")
			hit = 1'b1;
		if (n == 5'd3 && w[0] == "f" && w[1] == "o" && w[2] == "r")
			hit = 1'b1;
		if (n == 5'd4 && w[0] == "v" && w[1] == "o" && w[2] == "i" && w[3] == "d")
			hit = 1'b1;
		if (n == 5'd4 && w[0] == "m" && w[1] == "a" && w[2] == "i" && w[3] == "n")
			hit = 1'b1;
		if (n == 5'd5 && w[0] == "w" && w[1] == "h" && w[2] == "i" && w[3] == "l"
			&& w[4] == "e")
			hit = 1'b1;
		if (n == 5'd5 && w[0] == "f" && w[1] == "l" && w[2] == "o" && w[3] == "a"
			&& w[4] == "t")
			hit = 1'b1;
		return hit;
	endfunction

endpackage

`default_nettype wire

>>> design/lts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used by lts_dp for the symbol store.
`timescale 1ns / 1ps
`default_nettype none

module lts_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire  [AW-1:0]        waddr,
	input  wire  [WIDTH-1:0]     wdata,
	input  wire  [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

>>> design/lts_ctrl.sv
// Sequencing state machine of the token scanner.
// Depends on lts_pkg; drives lts_dp through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lts_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              char_valid,
	output logic             char_stall,
	input  lts_pkg::status_t st,
	output lts_pkg::cmd_t    cmd
);
	lts_pkg::state_t state_q, state_d;
	lts_pkg::kind_t  buf_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lts_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Kind of a lexeme sent out of the buffer follows the mode it was built in.
	always_comb begin
		if (st.mode == lts_pkg::MODE_NUM)
			buf_kind = lts_pkg::KIND_NUM;
		else if (st.kw_hit)
			buf_kind = lts_pkg::KIND_KW;
		else
			buf_kind = lts_pkg::KIND_NEWID;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lts_pkg::ST_IDLE:
				if (char_valid) state_d = lts_pkg::ST_DECIDE;
			lts_pkg::ST_DECIDE: begin
				if (st.eoi)
					state_d = lts_pkg::ST_FIN;
				else if (st.mode == lts_pkg::MODE_OP && st.pair_ok)
					state_d = lts_pkg::ST_PAIR0;
				else if (st.mode == lts_pkg::MODE_NUM && st.c_digit)
					state_d = lts_pkg::ST_IDLE;
				else if (st.mode == lts_pkg::MODE_ID && st.c_ident)
					state_d = lts_pkg::ST_IDLE;
				else
					state_d = lts_pkg::ST_FIN;
			end
			lts_pkg::ST_FIN: begin
				unique case (st.mode)
					lts_pkg::MODE_IDLE: state_d = lts_pkg::ST_FIN_END;
					lts_pkg::MODE_OP:   state_d = lts_pkg::ST_FIN_OP;
					lts_pkg::MODE_NUM:  state_d = lts_pkg::ST_EMIT_BUF;
					lts_pkg::MODE_ID:
						state_d = st.kw_hit ? lts_pkg::ST_EMIT_BUF : lts_pkg::ST_SRCH_LEN;
					default: state_d = lts_pkg::ST_FIN_END;
				endcase
			end
			lts_pkg::ST_FIN_OP:
				if (st.out_free) state_d = lts_pkg::ST_FIN_END;
			lts_pkg::ST_EMIT_BUF:
				if (st.out_free && st.i_last) state_d = lts_pkg::ST_FIN_END;
			lts_pkg::ST_SRCH_LEN: begin
				if (st.j_end)
					state_d = st.full ? lts_pkg::ST_FULL : lts_pkg::ST_STORE;
				else
					state_d = lts_pkg::ST_SRCH_CHK;
			end
			lts_pkg::ST_SRCH_CHK:
				state_d = st.len_eq ? lts_pkg::ST_SRCH_CMP : lts_pkg::ST_SRCH_LEN;
			lts_pkg::ST_SRCH_CMP: begin
				if (!st.chr_eq)
					state_d = lts_pkg::ST_SRCH_LEN;
				else if (st.i_last)
					state_d = lts_pkg::ST_FIN_END;
			end
			lts_pkg::ST_STORE:
				if (st.i_last) state_d = lts_pkg::ST_EMIT_BUF;
			lts_pkg::ST_FULL:
				if (st.out_free) state_d = lts_pkg::ST_FIN_END;
			lts_pkg::ST_FIN_END:
				state_d = st.eoi ? lts_pkg::ST_IDLE : lts_pkg::ST_START;
			lts_pkg::ST_PAIR0:
				if (st.out_free) state_d = lts_pkg::ST_PAIR1;
			lts_pkg::ST_PAIR1:
				if (st.out_free) state_d = lts_pkg::ST_IDLE;
			lts_pkg::ST_START:
				if (!st.c_special || st.out_free) state_d = lts_pkg::ST_IDLE;
			default: state_d = lts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		char_stall = (state_q != lts_pkg::ST_IDLE);
		unique case (state_q)
			lts_pkg::ST_IDLE:
				cmd.accept = char_valid;
			lts_pkg::ST_DECIDE:
				if (!st.eoi && ((st.mode == lts_pkg::MODE_NUM && st.c_digit)
					|| (st.mode == lts_pkg::MODE_ID && st.c_ident)))
					cmd.append = 1'b1;
			lts_pkg::ST_FIN: begin
				cmd.i_clr = 1'b1;
				cmd.j_clr = 1'b1;
			end
			lts_pkg::ST_FIN_OP: begin
				cmd.src  = lts_pkg::SRC_PEND;
				cmd.kind = lts_pkg::KIND_OP;
				cmd.last = 1'b1;
				cmd.emit = st.out_free;
				cmd.bump = st.out_free;
			end
			lts_pkg::ST_EMIT_BUF: begin
				cmd.src  = lts_pkg::SRC_BUF;
				cmd.kind = buf_kind;
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.i_inc   = 1'b1;
					cmd.bump    = st.i_last && (buf_kind != lts_pkg::KIND_NEWID);
					cmd.cnt_inc = st.i_last && (buf_kind == lts_pkg::KIND_NEWID);
				end
			end
			lts_pkg::ST_SRCH_LEN:
				cmd.i_clr = st.j_end;
			lts_pkg::ST_SRCH_CHK: begin
				cmd.i_clr = st.len_eq;
				cmd.j_inc = !st.len_eq;
			end
			lts_pkg::ST_SRCH_CMP: begin
				cmd.j_inc = !st.chr_eq;
				cmd.i_inc = st.chr_eq && !st.i_last;
			end
			lts_pkg::ST_STORE: begin
				cmd.wr_sym = 1'b1;
				cmd.i_inc  = !st.i_last;
				cmd.i_clr  = st.i_last;
			end
			lts_pkg::ST_FULL: begin
				cmd.src  = lts_pkg::SRC_ZERO;
				cmd.kind = lts_pkg::KIND_FULL;
				cmd.last = 1'b1;
				cmd.emit = st.out_free;
			end
			lts_pkg::ST_FIN_END:
				cmd.fin_done = 1'b1;
			lts_pkg::ST_PAIR0: begin
				cmd.src  = lts_pkg::SRC_PEND;
				cmd.kind = lts_pkg::KIND_OP;
				cmd.emit = st.out_free;
			end
			lts_pkg::ST_PAIR1: begin
				cmd.src      = lts_pkg::SRC_CHAR;
				cmd.kind     = lts_pkg::KIND_OP;
				cmd.last     = 1'b1;
				cmd.emit     = st.out_free;
				cmd.bump     = st.out_free;
				cmd.set_mode = st.out_free;
				cmd.mode     = lts_pkg::MODE_IDLE;
			end
			lts_pkg::ST_START: begin
				if (st.c_op) begin
					cmd.set_mode  = 1'b1;
					cmd.mode      = lts_pkg::MODE_OP;
					cmd.load_pend = 1'b1;
				end else if (st.c_special) begin
					cmd.src  = lts_pkg::SRC_CHAR;
					cmd.kind = lts_pkg::KIND_SPECIAL;
					cmd.last = 1'b1;
					cmd.emit = st.out_free;
					cmd.bump = st.out_free;
				end else if (st.c_digit) begin
					cmd.set_mode = 1'b1;
					cmd.mode     = lts_pkg::MODE_NUM;
					cmd.append   = 1'b1;
				end else if (st.c_alpha) begin
					cmd.set_mode = 1'b1;
					cmd.mode     = lts_pkg::MODE_ID;
					cmd.append   = 1'b1;
				end else if (st.c_nl) begin
					cmd.line_inc = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end
endmodule

`default_nettype wire

>>> design/lts_dp.sv
// Datapath of the token scanner: lexeme buffer, counters, symbol store, result register.
// Depends on lts_pkg and lts_ram; commanded by lts_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lts_dp #(
	parameter int MAX_LEN     = lts_pkg::MAX_LEN_DEF,
	parameter int SYM_ENTRIES = lts_pkg::SYM_ENTRIES_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [7:0]       char_code,
	input  wire              end_of_input,
	input  wire              tok_stall,
	input  lts_pkg::cmd_t    cmd,
	output lts_pkg::status_t st,
	output logic             tok_valid,
	output logic [2:0]       kind,
	output logic [7:0]       lexeme_char,
	output logic [15:0]      line_number,
	output logic [15:0]      token_number,
	output logic [7:0]       symbol_id,
	output logic             last
);
	localparam int LW     = $clog2(MAX_LEN + 1);
	localparam int IW     = $clog2(MAX_LEN);
	localparam int CW     = $clog2(SYM_ENTRIES + 1);
	localparam int NDEPTH = SYM_ENTRIES * MAX_LEN;
	localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
	localparam int BW     = $clog2(NDEPTH + 1);
	localparam int LAW    = (SYM_ENTRIES > 1) ? $clog2(SYM_ENTRIES) : 1;

	logic [7:0]          c_q;
	logic                eoi_q;
	lts_pkg::mode_t      mode_q;
	logic [7:0]          pend_q;
	logic [7:0]          buf_q [MAX_LEN];
	logic [LW-1:0]       len_q;
	logic [15:0]         line_q;
	logic [15:0]         tokn_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       j_q;
	logic [BW-1:0]       base_q;
	logic [IW-1:0]       i_q, i_d;
	logic [4:0][7:0]     kw_win;
	logic [7:0]          buf_rd;
	logic [7:0]          name_rdata;
	logic [LW-1:0]       len_rdata;
	logic [BW-1:0]       name_raddr, name_waddr;
	logic                i_last;
	logic                out_free;
	logic [7:0]          out_ch;

	assign buf_rd   = buf_q[i_q];
	assign i_last   = (LW'(i_q) + LW'(1)) == len_q;
	assign out_free = !tok_valid || !tok_stall;

	for (genvar k = 0; k < 5; k++) begin : g_kw
		if (k < MAX_LEN) begin : g_in
			assign kw_win[k] = buf_q[k];
		end else begin : g_out
			assign kw_win[k] = 8'h00;
		end
	end

	always_comb begin
		i_d = i_q;
		if (cmd.i_clr)
			i_d = '0;
		else if (cmd.i_inc)
			i_d = i_q + IW'(1);
	end

	assign name_raddr = base_q + BW'(i_d);
	assign name_waddr = base_q + BW'(i_q);

	lts_ram #(.WIDTH(8), .DEPTH(NDEPTH)) u_names (
		.clk   (clk),
		.we    (cmd.wr_sym),
		.waddr (name_waddr[NAW-1:0]),
		.wdata (buf_rd),
		.raddr (name_raddr[NAW-1:0]),
		.rdata (name_rdata)
	);

	lts_ram #(.WIDTH(LW), .DEPTH(SYM_ENTRIES)) u_lens (
		.clk   (clk),
		.we    (cmd.wr_sym),
		.waddr (cnt_q[LAW-1:0]),
		.wdata (len_q),
		.raddr (j_q[LAW-1:0]),
		.rdata (len_rdata)
	);

	always_comb begin
		st.mode      = mode_q;
		st.eoi       = eoi_q;
		st.c_op      = (c_q == lts_pkg::CH_PLUS) || (c_q == lts_pkg::CH_MINUS)
			|| (c_q == lts_pkg::CH_STAR) || (c_q == lts_pkg::CH_SLASH)
			|| (c_q == lts_pkg::CH_EQ) || (c_q == lts_pkg::CH_BANG)
			|| (c_q == lts_pkg::CH_LT) || (c_q == lts_pkg::CH_GT);
		st.c_special = (c_q == lts_pkg::CH_SEMI) || (c_q == lts_pkg::CH_LBRACE)
			|| (c_q == lts_pkg::CH_RBRACE) || (c_q == lts_pkg::CH_LPAREN)
			|| (c_q == lts_pkg::CH_RPAREN) || (c_q == lts_pkg::CH_QUEST)
			|| (c_q == lts_pkg::CH_AT) || (c_q == lts_pkg::CH_PCT)
			|| (c_q == lts_pkg::CH_COMMA) || (c_q == lts_pkg::CH_LBRACK)
			|| (c_q == lts_pkg::CH_RBRACK);
		st.c_digit   = (c_q >= "0") && (c_q <= "9");
		st.c_alpha   = ((c_q >= "a") && (c_q <= "z")) || ((c_q >= "A") && (c_q <= "Z"));
		st.c_nl      = (c_q == lts_pkg::CH_NL);
		st.c_ident   = st.c_alpha || st.c_digit || (c_q == lts_pkg::CH_UNDER);
		st.pair_ok   = (c_q == lts_pkg::CH_EQ) && ((pend_q == lts_pkg::CH_EQ)
			|| (pend_q == lts_pkg::CH_BANG) || (pend_q == lts_pkg::CH_LT)
			|| (pend_q == lts_pkg::CH_GT));
		st.kw_hit    = lts_pkg::is_keyword(kw_win, 5'(len_q));
		st.j_end     = (j_q == cnt_q);
		st.full      = (cnt_q == CW'(SYM_ENTRIES));
		st.len_eq    = (len_rdata == len_q);
		st.chr_eq    = (name_rdata == buf_rd);
		st.i_last    = i_last;
		st.out_free  = out_free;
	end

	always_comb begin
		unique case (cmd.src)
			lts_pkg::SRC_BUF:  out_ch = buf_rd;
			lts_pkg::SRC_PEND: out_ch = pend_q;
			lts_pkg::SRC_CHAR: out_ch = c_q;
			lts_pkg::SRC_ZERO: out_ch = 8'h00;
			default:           out_ch = 8'h00;
		endcase
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			c_q   <= char_code;
			eoi_q <= end_of_input;
		end
		if (cmd.load_pend)
			pend_q <= c_q;
		for (int k = 0; k < MAX_LEN; k++) begin
			if (cmd.append && len_q == LW'(k))
				buf_q[k] <= c_q;
		end
		if (cmd.emit) begin
			kind         <= cmd.kind;
			lexeme_char  <= out_ch;
			line_number  <= line_q;
			token_number <= tokn_q;
			symbol_id    <= (cmd.kind == lts_pkg::KIND_NEWID) ? 8'(cnt_q) : 8'h00;
			last         <= (cmd.src == lts_pkg::SRC_BUF) ? i_last : cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lts_pkg::MODE_IDLE;
			len_q     <= '0;
			line_q    <= 16'd1;
			tokn_q    <= 16'd1;
			cnt_q     <= '0;
			j_q       <= '0;
			base_q    <= '0;
			i_q       <= '0;
			tok_valid <= 1'b0;
		end else begin
			i_q <= i_d;
			if (cmd.fin_done)
				mode_q <= lts_pkg::MODE_IDLE;
			else if (cmd.set_mode)
				mode_q <= cmd.mode;
			if (cmd.fin_done)
				len_q <= '0;
			else if (cmd.append && len_q < LW'(MAX_LEN))
				len_q <= len_q + LW'(1);
			if (cmd.line_inc && line_q != 16'hFFFF)
				line_q <= line_q + 16'd1;
			if (cmd.bump && tokn_q != 16'hFFFF)
				tokn_q <= tokn_q + 16'd1;
			if (cmd.cnt_inc)
				cnt_q <= cnt_q + CW'(1);
			if (cmd.j_clr) begin
				j_q    <= '0;
				base_q <= '0;
			end else if (cmd.j_inc) begin
				j_q    <= j_q + CW'(1);
				base_q <= base_q + BW'(MAX_LEN);
			end
			if (cmd.emit)
				tok_valid <= 1'b1;
			else if (!tok_stall)
				tok_valid <= 1'b0;
		end
	end
endmodule

`default_nettype wire

>>> design/lexical_token_scanner_core.sv
// Top level of the lexical token scanner: joins the controller and the datapath.
// Depends on lts_pkg, lts_ctrl, lts_dp and lts_ram.
`timescale 1ns / 1ps
`default_nettype none

// The scanner takes one byte of source text per word on the char channel and sends
// each finished token as a run of words on the tok channel, one per lexeme character,
// with last set on the final one. Operators, special symbols, numbers and keywords are
// always reported; an identifier is reported only when first seen, with a fresh
// symbol id, and a new identifier that finds the symbol store full gives a single
// table-full word. A byte that does not extend a number or identifier and is not the
// second byte of a two-character operator passes through the token-finishing steps
// even when nothing is pending; a byte that ends a token also waits for each result
// word to be taken. Ending an identifier that is not a keyword runs a search over the
// symbol store, which has one read port: each stored symbol's length is checked first,
// and when the lengths agree its characters are compared one by one; a new symbol is
// then stored one character at a time. The input is held off (char_stall high) for the
// whole time; a waiting result word never blocks the next input byte, only the next
// result. The symbol store needs no clearing after reset.

module lexical_token_scanner_core #(
	parameter int MAX_LEN     = lts_pkg::MAX_LEN_DEF,
	parameter int SYM_ENTRIES = lts_pkg::SYM_ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         char_valid,
	output logic        char_stall,
	input  wire  [7:0]  char_code,
	input  wire         end_of_input,
	output logic        tok_valid,
	input  wire         tok_stall,
	output logic [2:0]  kind,
	output logic [7:0]  lexeme_char,
	output logic [15:0] line_number,
	output logic [15:0] token_number,
	output logic [7:0]  symbol_id,
	output logic        last
);
	lts_pkg::cmd_t    cmd;
	lts_pkg::status_t st;

	// The controller sequences every byte; it alone decides when input is taken.
	lts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.st         (st),
		.cmd        (cmd)
	);

	// The datapath holds all token state, the symbol store and the result register.
	lts_dp #(
		.MAX_LEN     (MAX_LEN),
		.SYM_ENTRIES (SYM_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.tok_stall    (tok_stall),
		.cmd          (cmd),
		.st           (st),
		.tok_valid    (tok_valid),
		.kind         (kind),
		.lexeme_char  (lexeme_char),
		.line_number  (line_number),
		.token_number (token_number),
		.symbol_id    (symbol_id),
		.last         (last)
	);

`ifndef ASSERT_OFF
	// Words of one token share its kind, line and token number.
	a_run_same: assert property (@(posedge clk) disable iff (!arst_n)
		($past(tok_valid && !tok_stall && !last) && tok_valid) |->
		(token_number == $past(token_number) && line_number == $past(line_number)
		&& kind == $past(kind)))
		else $error("token run changed kind, line or token number");

	// Only a new identifier carries a symbol id.
	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && kind != lts_pkg::KIND_NEWID) |-> (symbol_id == 8'h00))
		else $error("symbol id on a word that is not a new identifier");

	// A table-full report is a single empty word.
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && kind == lts_pkg::KIND_FULL) |-> (last && lexeme_char == 8'h00))
		else $error("malformed table-full word");
`endif
endmodule

`default_nettype wire

>>> verif/lts_token_checker.sv
// Token checker for the lexical token scanner: watches the char and tok channels,
// predicts every token word and compares it with what the block sends.
// Depends on lts_pkg for the mode and kind codes.
`timescale 1ns / 1ps

module lts_token_checker
	import lts_pkg::*;
#(
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int SYM_ENTRIES = SYM_ENTRIES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        char_valid,
	input  wire        char_stall,
	input  wire [7:0]  char_code,
	input  wire        end_of_input,
	input  wire        tok_valid,
	input  wire        tok_stall,
	input  wire [2:0]  kind,
	input  wire [7:0]  lexeme_char,
	input  wire [15:0] line_number,
	input  wire [15:0] token_number,
	input  wire [7:0]  symbol_id,
	input  wire        last,
	output int         failures,
	output int         words_due,
	output int         words_checked,
	output int         full_words
);

	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [15:0] line;
		logic [15:0] tok;
		logic [7:0]  sym;
		logic        last;
	} token_word_t;

	token_word_t token_words_due[$];

	// Shadow copy of the scanner state.
	mode_t      scan_mode;
	logic [7:0] held_op;
	logic [7:0] lexeme[MAX_LEN];
	int         lexeme_len;
	int         line_cnt;
	int         token_cnt;
	int         sym_cnt;
	logic [7:0] sym_text[SYM_ENTRIES][MAX_LEN];
	int         sym_len[SYM_ENTRIES];

	function automatic bit is_op_char(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
	endfunction

	function automatic bit is_special_char(logic [7:0] c);
		return c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
			c == CH_RPAREN || c == CH_QUEST || c == CH_AT || c == CH_PCT ||
			c == CH_COMMA || c == CH_LBRACK || c == CH_RBRACK;
	endfunction

	function automatic bit is_digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	task automatic push_word(kind_t k, logic [7:0] c, logic [7:0] sid, logic l);
		token_word_t w;
		w.kind = k;
		w.ch   = c;
		w.line = line_cnt[15:0];
		w.tok  = token_cnt[15:0];
		w.sym  = sid;
		w.last = l;
		token_words_due.push_back(w);
	endtask

	task automatic bump_token();
		if (token_cnt < 65535)
			token_cnt++;
	endtask

	task automatic push_lexeme(kind_t k, logic [7:0] sid);
		for (int i = 0; i < lexeme_len; i++)
			push_word(k, lexeme[i], sid, i == lexeme_len - 1);
	endtask

	function automatic bit lexeme_is_keyword();
		string s;
		s = "";
		for (int i = 0; i < lexeme_len; i++)
			s = {s, string'(lexeme[i])};
		return s == "if" || s == "int" || s == "void" || s == "while" ||
			s == "float" || s == "for" || s == "main";
	endfunction

	// Keywords are always reported; other names only when first stored.
	task automatic close_identifier();
		bit same;
		if (lexeme_is_keyword()) begin
			push_lexeme(KIND_KW, 8'd0);
			bump_token();
			return;
		end
		for (int j = 0; j < sym_cnt && j < SYM_ENTRIES; j++) begin
			same = sym_len[j] == lexeme_len;
			for (int i = 0; i < lexeme_len && same; i++)
				if (sym_text[j][i] != lexeme[i])
					same = 0;
			if (same)
				return;
		end
		if (sym_cnt >= SYM_ENTRIES) begin
			push_word(KIND_FULL, 8'd0, 8'd0, 1'b1);
			return;
		end
		for (int i = 0; i < lexeme_len; i++)
			sym_text[sym_cnt][i] = lexeme[i];
		sym_len[sym_cnt] = lexeme_len;
		push_lexeme(KIND_NEWID, sym_cnt[7:0]);
		sym_cnt++;
	endtask

	task automatic close_token();
		case (scan_mode)
			MODE_OP: begin
				push_word(KIND_OP, held_op, 8'd0, 1'b1);
				bump_token();
			end
			MODE_NUM: begin
				push_lexeme(KIND_NUM, 8'd0);
				bump_token();
			end
			MODE_ID: close_identifier();
			default: ;
		endcase
		scan_mode  = MODE_IDLE;
		lexeme_len = 0;
	endtask

	task automatic add_char(logic [7:0] c);
		if (lexeme_len < MAX_LEN) begin
			lexeme[lexeme_len] = c;
			lexeme_len++;
		end
	endtask

	task automatic open_token(logic [7:0] c);
		if (is_op_char(c)) begin
			scan_mode = MODE_OP;
			held_op   = c;
		end else if (is_special_char(c)) begin
			push_word(KIND_SPECIAL, c, 8'd0, 1'b1);
			bump_token();
		end else if (is_digit_char(c)) begin
			scan_mode  = MODE_NUM;
			lexeme_len = 0;
			add_char(c);
		end else if (is_letter(c)) begin
			scan_mode  = MODE_ID;
			lexeme_len = 0;
			add_char(c);
		end else if (c == CH_NL) begin
			if (line_cnt < 65535)
				line_cnt++;
		end
	endtask

	task automatic scan_byte(logic [7:0] c, logic eoi);
		if (eoi) begin
			close_token();
			return;
		end
		case (scan_mode)
			MODE_OP: begin
				if (c == CH_EQ && (held_op == CH_EQ || held_op == CH_BANG ||
						held_op == CH_LT || held_op == CH_GT)) begin
					push_word(KIND_OP, held_op, 8'd0, 1'b0);
					push_word(KIND_OP, c, 8'd0, 1'b1);
					bump_token();
					scan_mode = MODE_IDLE;
					return;
				end
				close_token();
			end
			MODE_NUM: begin
				if (is_digit_char(c)) begin
					add_char(c);
					return;
				end
				close_token();
			end
			MODE_ID: begin
				if (is_letter(c) || is_digit_char(c) || c == CH_UNDER) begin
					add_char(c);
					return;
				end
				close_token();
			end
			default: ;
		endcase
		open_token(c);
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	initial begin
		failures      = 0;
		words_checked = 0;
		full_words    = 0;
		scan_mode     = MODE_IDLE;
		held_op       = 8'd0;
		lexeme_len    = 0;
		line_cnt      = 1;
		token_cnt     = 1;
		sym_cnt       = 0;
	end

	always @(posedge clk) begin
		token_word_t w;
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				if (token_words_due.size() == 0) begin
					$error("unexpected token word: kind %0d char %0d", kind, lexeme_char);
					failures++;
				end else begin
					w = token_words_due.pop_front();
					check_field("kind", w.kind, kind);
					check_field("lexeme_char", w.ch, lexeme_char);
					check_field("line_number", w.line, line_number);
					check_field("token_number", w.tok, token_number);
					check_field("symbol_id", w.sym, symbol_id);
					check_field("last", w.last, last);
					if (w.kind == KIND_FULL)
						full_words++;
					words_checked++;
				end
			end
			if (char_valid && !char_stall)
				scan_byte(char_code, end_of_input);
		end
		words_due = token_words_due.size();
	end

endmodule

>>> verif/lexical_token_scanner_core_tb.sv
// Testbench top for the lexical token scanner: clock, reset, byte stimulus and verdict.
// Depends on lts_pkg, lexical_token_scanner_core and lts_token_checker.
`timescale 1ns / 1ps

module lexical_token_scanner_core_tb;
	import lts_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  char_code;
	logic        end_of_input;
	logic        tok_valid;
	logic        tok_stall;
	logic [2:0]  kind;
	logic [7:0]  lexeme_char;
	logic [15:0] line_number;
	logic [15:0] token_number;
	logic [7:0]  symbol_id;
	logic        last;

	int failures;
	int words_due;
	int words_checked;
	int full_words;
	int bytes_sent;
	int cycle_cnt;
	// When set, neither side idles: used for the closing stretch of the run.
	bit quiet;
	int tok_hold;

	lexical_token_scanner_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall),
		.char_code(char_code), .end_of_input(end_of_input),
		.tok_valid(tok_valid), .tok_stall(tok_stall),
		.kind(kind), .lexeme_char(lexeme_char), .line_number(line_number),
		.token_number(token_number), .symbol_id(symbol_id), .last(last)
	);

	lts_token_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall),
		.char_code(char_code), .end_of_input(end_of_input),
		.tok_valid(tok_valid), .tok_stall(tok_stall),
		.kind(kind), .lexeme_char(lexeme_char), .line_number(line_number),
		.token_number(token_number), .symbol_id(symbol_id), .last(last),
		.failures(failures), .words_due(words_due),
		.words_checked(words_checked), .full_words(full_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("lexical_token_scanner_core: mismatch");
			$finish;
		end
	end

	// The receiver stalls in random bursts.
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			tok_stall <= 1'b0;
			tok_hold  <= 0;
		end else if (tok_hold > 0) begin
			tok_hold <= tok_hold - 1;
			if (tok_hold == 1)
				tok_stall <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			tok_stall <= 1'b1;
			tok_hold  <= $urandom_range(1, 7);
		end
	end

	// Present one word on the char channel and hold it until it is taken. A random
	// gap may follow, so that idle cycles land on every phase of the scanner's work.
	task automatic put_byte(logic [7:0] c, logic eoi);
		int gap;
		char_valid   <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		do
			@(posedge clk);
		while (char_stall);
		bytes_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			char_valid   <= 1'b0;
			char_code    <= 8'($urandom);
			end_of_input <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i], 1'b0);
	endtask

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 51);
		return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] pick_name_char();
		int r;
		r = $urandom_range(0, 12);
		if (r < 8)
			return pick_letter();
		if (r < 12)
			return 8'("0" + $urandom_range(0, 9));
		return CH_UNDER;
	endfunction

	// Byte that separates tokens: mostly blanks and newlines, sometimes any byte.
	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 5))
			0, 1: return " ";
			2: return CH_NL;
			3: return 8'($urandom_range(128, 255));
			4: return 8'h09;
			default: return 8'($urandom);
		endcase
	endfunction

	// One random token; a small pool of names makes repeated identifiers common.
	task automatic put_random_token();
		string ops[$]    = '{"+", "-", "*", "/", "=", "!", "<", ">", "==", "!=", "<=", ">="};
		string specs     = ";{}()?@%,[]";
		string kwords[$] = '{"if", "int", "void", "while", "float", "for", "main"};
		string pool[$]   = '{"x", "y1", "count", "i_", "Tmp9", "ifx", "in"};
		int len;
		case ($urandom_range(0, 9))
			0: put_text(ops[$urandom_range(0, ops.size() - 1)]);
			1: put_byte(specs[$urandom_range(0, specs.len() - 1)], 1'b0);
			2: put_text(kwords[$urandom_range(0, kwords.size() - 1)]);
			3, 4: put_text(pool[$urandom_range(0, pool.size() - 1)]);
			5, 6: begin
				// Fresh name; some run past the lexeme limit.
				len = $urandom_range(0, 7) == 0 ? $urandom_range(18, 26) : $urandom_range(1, 6);
				put_byte(pick_letter(), 1'b0);
				for (int i = 1; i < len; i++)
					put_byte(pick_name_char(), 1'b0);
			end
			7: begin
				len = $urandom_range(0, 7) == 0 ? $urandom_range(18, 24) : $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					put_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
			end
			8: put_byte(8'($urandom), 1'b0);
			default: put_byte(8'($urandom), 1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (words_due != 0);
	endtask

	initial begin
		bit paused;
		quiet        = 1'b0;
		paused       = 1'b0;
		bytes_sent   = 0;
		cycle_cnt    = 0;
		arst_n       = 1'b0;
		char_valid   = 1'b0;
		char_code    = 8'd0;
		end_of_input = 1'b0;
		tok_stall    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a keyword, a repeated name, all two-character operators,
		// an operator cut short by another byte, a high byte ending a number, and
		// an operator still waiting when the end marker arrives.
		put_text("if x_1 x_1\n==!=<=>=<a;9");
		put_byte(8'hFF, 1'b0);
		put_byte("!", 1'b0);
		put_byte(8'h00, 1'b1);

		// Random part with a pause that lets every pending word drain.
		while (bytes_sent < 430) begin
			put_random_token();
			if ($urandom_range(0, 2) != 0)
				put_byte(pick_separator(), 1'b0);
			if (!paused && bytes_sent > 230) begin
				paused = 1'b1;
				char_valid <= 1'b0;
				wait_drained();
			end
		end

		// Closing stretch without idling on either side.
		quiet = 1'b1;
		while (bytes_sent < 462) begin
			put_random_token();
			if ($urandom_range(0, 2) != 0)
				put_byte(pick_separator(), 1'b0);
		end
		put_text("while 7");
		put_byte(8'h00, 1'b1);
		char_valid <= 1'b0;

		wait_drained();
		repeat (50) @(posedge clk);
		$display("Sent %0d bytes and checked %0d token words (%0d table-full words).",
			bytes_sent, words_checked, full_words);
		$display("Covered operators, specials, numbers, keywords, new and repeated names, "
			, "long lexemes, stray bytes and end markers under stalls on both sides.");
		if (failures == 0) begin
			$display("lexical_token_scanner_core: match");
		end else begin
			$display("lexical_token_scanner_core: mismatch");
		end
		$finish;
	end

endmodule

>>> files.f
design/lts_pkg.sv
design/lts_ram.sv
design/lts_ctrl.sv
design/lts_dp.sv
design/lexical_token_scanner_core.sv
verif/lts_token_checker.sv
verif/lexical_token_scanner_core_tb.sv
